/* rtl/cdm_pkg.sv */
`timescale 1ns / 1ps
package cdm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND     = 3'd0,
    REG_SLEW_STEP    = 3'd1,
    REG_TURN_NONLIN  = 3'd2,
    REG_INERTIA_GAIN = 3'd3,
    REG_TURN_SENS    = 3'd4
  } cfg_reg_t;

  localparam logic [14:0] DEADBAND_RST   = 15'd1638;
  localparam logic [14:0] SLEW_STEP_RST  = 15'd655;
  localparam logic [14:0] TURN_NONLIN_RST = 15'd21299;
  localparam logic [15:0] INERTIA_GAIN_RST = 16'd16384;
  localparam logic [15:0] TURN_SENS_RST  = 16'd4096;

  // pi/2 in Q2.30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic signed [17:0] OUT_MAX = 18'sd131071;
  localparam logic signed [23:0] ACC_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] ACC_MIN = 24'sh800000;
  localparam logic signed [23:0] ACC_ONE = 24'sd32768;

  function automatic logic signed [17:0] sat_out(input logic signed [32:0] v);
    logic signed [17:0] r;
    if (v > 33'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (v < -33'(OUT_MAX)) begin
      r = -OUT_MAX;
    end else begin
      r = 18'(v);
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat_acc(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'(ACC_MAX)) begin
      r = ACC_MAX;
    end else if (v < 26'(ACC_MIN)) begin
      r = ACC_MIN;
    end else begin
      r = 24'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/curvature_drive_mixer.sv */
`timescale 1ns / 1ps
// A shared multiplier and a bit-serial divider compute every sine term and remap quotient,
// so the block takes no new input until the result of the last one is parked.
// in_stall is high from transfer until the result is parked in the output register.
// Reset (rst_n, synchronous, active low) loads register defaults, clears history,
// the inertia accumulator and the output valid.
module curvature_drive_mixer #(
  parameter int FRAC_BITS       = 15,
  parameter int SINE_ITERATIONS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [15:0]                    in_throttle,
  input  logic signed [15:0]                    in_turn,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [17:0]                    out_left_drive,
  output logic signed [17:0]                    out_right_drive,
  output logic                                  out_turning_in_place,
  input  logic                                  cfg_we,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cdm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  // working width of the sine datapath: QF with headroom to +-8
  localparam int W   = FRAC_BITS + 4;
  localparam int MW  = (W > 26) ? W : 26;          // multiplier operand width
  localparam int PW  = 2 * MW;
  localparam int DW  = W + FRAC_BITS;              // divider dividend/quotient width
  localparam int CW  = $clog2(DW + 1);
  localparam int NW  = $clog2(SINE_ITERATIONS);
  localparam int DVW = $clog2(4 * SINE_ITERATIONS * SINE_ITERATIONS);
  localparam int UP  = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int DN  = (FRAC_BITS >= 15) ? 0 : 15 - FRAC_BITS;
  localparam logic signed [W-1:0] ONE     = W'(longint'(1) << FRAC_BITS);
  localparam logic signed [W-1:0] HALF_PI = W'(cdm_pkg::HALF_PI_Q30 >> (30 - FRAC_BITS));

  typedef enum logic [3:0] {
    S_IDLE, S_SIN_A, S_SIN_A2, S_SIN_T, S_DIV, S_SIN_NEXT,
    S_R_START, S_R_U, S_R_DONE, S_TAIL, S_IP, S_PWR, S_ANG1, S_ANG2, S_OUT
  } state_t;

  // which sine evaluation is running: the normalizer, then the two remap passes
  typedef enum logic [1:0] {PH_DEN, PH_P1, PH_P2} phase_t;

  // ---------------------------------------------------------------- config
  logic [14:0] deadband_r, slew_r, nonlin_r;
  logic [15:0] gain_r, sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= cdm_pkg::DEADBAND_RST;
      slew_r     <= cdm_pkg::SLEW_STEP_RST;
      nonlin_r   <= cdm_pkg::TURN_NONLIN_RST;
      gain_r     <= cdm_pkg::INERTIA_GAIN_RST;
      sens_r     <= cdm_pkg::TURN_SENS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cdm_pkg::REG_DEADBAND:     deadband_r <= cfg_wdata[14:0];
        cdm_pkg::REG_SLEW_STEP:    slew_r     <= cfg_wdata[14:0];
        cdm_pkg::REG_TURN_NONLIN:  nonlin_r   <= cfg_wdata[14:0];
        cdm_pkg::REG_INERTIA_GAIN: gain_r     <= cfg_wdata;
        cdm_pkg::REG_TURN_SENS:    sens_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- registers
  state_t                  state_r, ret_r;
  phase_t                  phase_r;
  logic signed [15:0]      last_thr_r, last_turn_r;
  logic signed [23:0]      inertia_r;
  logic signed [17:0]      cmd_r;
  logic signed [16:0]      dturn_r;
  logic                    in_place_r;
  logic signed [W-1:0]     r_r, den_r, term_r, sum_r, a2_r;
  logic signed [16:0]      rq_r;
  logic signed [MW-1:0]    ma_r, mb_r;
  logic [NW-1:0]           n_r;
  logic [DVW-1:0]          dv_r;
  logic [DW-1:0]           dvd_r, quo_r;
  logic [W-1:0]            dsr_r, rem_r;
  logic [CW-1:0]           cnt_r;
  logic                    div_neg_r;
  logic signed [17:0]      res_left_r, res_right_r;
  logic                    out_valid_r;
  logic signed [17:0]      out_left_r, out_right_r;
  logic                    out_tip_r;

  // ---------------------------------------------------------------- combinational
  logic signed [PW-1:0]    prod;
  logic signed [W-1:0]     prod_f, prod_f_abs;
  logic signed [PW-1:0]    prod_15, prod_12;
  logic signed [31:0]      k_w, v_w, rq_w;
  logic signed [W-1:0]     k_qf, v_qf;
  logic signed [16:0]      thr17, trn17, athr, atrn;
  logic signed [17:0]      dth, cmd_in, slew1, slew2;
  logic                    in_place_in;
  logic signed [W-1:0]     tmag, term_new, sum_new, sum_abs, rmag, r_new;
  logic [W:0]              rem_sh;
  logic                    div_ge;
  logic signed [25:0]      inr_sum;
  logic signed [23:0]      inr_new;
  logic signed [17:0]      acmd;
  logic signed [31:0]      ang;

  assign prod       = PW'(ma_r) * PW'(mb_r);
  assign prod_f     = W'(prod >>> FRAC_BITS);
  assign prod_f_abs = (prod_f < 0) ? -prod_f : prod_f;
  assign prod_15    = prod >>> 15;
  assign prod_12    = prod >>> 12;

  // Q1.15 <-> QF conversions (floor when narrowing)
  assign k_w  = (32'($signed({1'b0, nonlin_r})) <<< UP) >>> DN;
  assign k_qf = W'(k_w);
  assign v_w  = (32'(in_turn) <<< UP) >>> DN;
  assign v_qf = W'(v_w);
  assign rq_w = (32'(r_r) <<< DN) >>> UP;

  // branch and slew decision at transfer
  always_comb begin
    thr17 = 17'(in_throttle);
    trn17 = 17'(in_turn);
    athr  = (thr17 < 0) ? -thr17 : thr17;
    atrn  = (trn17 < 0) ? -trn17 : trn17;
    dth   = 18'(in_throttle) - 18'(last_thr_r);
    slew1 = $signed({3'b000, slew_r});
    slew2 = $signed({2'b00, slew_r, 1'b0});
    in_place_in = (athr < $signed({2'b00, deadband_r})) &&
                  (atrn > $signed({2'b00, deadband_r}));
    if (in_place_in) begin
      cmd_in = '0;
    end else if (dth > slew1) begin
      cmd_in = 18'(last_thr_r) + slew1;
    end else if (dth < -slew2) begin
      cmd_in = 18'(last_thr_r) - slew2;
    end else begin
      cmd_in = 18'(in_throttle);
    end
  end

  // sine term and remap quotient from the divider
  always_comb begin
    tmag     = $signed(quo_r[W-1:0]);
    term_new = div_neg_r ? tmag : -tmag;
    sum_new  = sum_r + term_new;
    sum_abs  = (sum_new < 0) ? -sum_new : sum_new;
    rmag     = (quo_r > DW'(ONE)) ? ONE : $signed(quo_r[W-1:0]);
    r_new    = div_neg_r ? -rmag : rmag;
  end

  // one restoring divider step
  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign div_ge = (rem_sh >= {1'b0, dsr_r});

  // tail arithmetic in Q15
  always_comb begin
    inr_sum = 26'(inertia_r) + 26'(prod_12);
    inr_new = cdm_pkg::sat_acc(inr_sum);
    acmd    = (cmd_r < 0) ? -cmd_r : cmd_r;
    ang     = 32'(prod_12);
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      phase_r     <= PH_DEN;
      out_valid_r <= 1'b0;
      last_thr_r  <= '0;
      last_turn_r <= '0;
      inertia_r   <= '0;
    end else begin
      // S_OUT handles its own transfer when it reloads the output register
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r       <= cmd_in;
            in_place_r  <= in_place_in;
            dturn_r     <= trn17 - 17'(last_turn_r);
            last_thr_r  <= in_throttle;
            last_turn_r <= in_turn;
            r_r         <= v_qf;
            phase_r     <= PH_DEN;
            // normalizer: u = k
            ma_r        <= MW'(k_qf);
            mb_r        <= MW'(HALF_PI);
            state_r     <= S_SIN_A;
          end
        end
        S_SIN_A: begin
          // a = u * pi/2
          term_r  <= prod_f;
          sum_r   <= prod_f;
          ma_r    <= MW'(prod_f);
          mb_r    <= MW'(prod_f);
          n_r     <= NW'(1);
          dv_r    <= DVW'(6);
          state_r <= S_SIN_A2;
        end
        S_SIN_A2: begin
          a2_r    <= prod_f;
          ma_r    <= MW'(term_r);
          mb_r    <= MW'(prod_f);
          state_r <= S_SIN_T;
        end
        S_SIN_T: begin
          // term * a^2, then divide by (2n)(2n+1)
          dvd_r     <= DW'(prod_f_abs) << FRAC_BITS;
          dsr_r     <= W'(dv_r);
          rem_r     <= '0;
          quo_r     <= '0;
          cnt_r     <= CW'(W);
          div_neg_r <= (prod_f < 0);
          ret_r     <= S_SIN_NEXT;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r <= div_ge ? W'(rem_sh - {1'b0, dsr_r}) : rem_sh[W-1:0];
          quo_r <= {quo_r[DW-2:0], div_ge};
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_r <= ret_r;
          end
        end
        S_SIN_NEXT: begin
          term_r <= term_new;
          sum_r  <= sum_new;
          n_r    <= n_r + NW'(1);
          dv_r   <= dv_r + (DVW'(n_r) << 3) + DVW'(6);
          if (n_r == NW'(SINE_ITERATIONS - 1)) begin
            if (phase_r == PH_DEN) begin
              den_r   <= sum_new;
              phase_r <= PH_P1;
              state_r <= S_R_START;
            end else begin
              // sin(..) * one / den, truncated toward zero
              dvd_r     <= DW'(sum_abs) << FRAC_BITS;
              dsr_r     <= den_r;
              rem_r     <= '0;
              quo_r     <= '0;
              cnt_r     <= CW'(DW);
              div_neg_r <= (sum_new < 0);
              ret_r     <= S_R_DONE;
              state_r   <= S_DIV;
            end
          end else begin
            ma_r    <= MW'(term_new);
            mb_r    <= MW'(a2_r);
            state_r <= S_SIN_T;
          end
        end
        S_R_START: begin
          // degenerate shaping leaves the turn unchanged
          if (den_r <= 0) begin
            state_r <= S_TAIL;
          end else begin
            ma_r    <= MW'(k_qf);
            mb_r    <= MW'(r_r);
            state_r <= S_R_U;
          end
        end
        S_R_U: begin
          ma_r    <= MW'(prod_f);
          mb_r    <= MW'(HALF_PI);
          state_r <= S_SIN_A;
        end
        S_R_DONE: begin
          r_r <= r_new;
          if (phase_r == PH_P1) begin
            phase_r <= PH_P2;
            state_r <= S_R_START;
          end else begin
            state_r <= S_TAIL;
          end
        end
        S_TAIL: begin
          rq_r <= 17'(rq_w);
          if (in_place_r) begin
            ma_r    <= MW'(17'(rq_w));
            mb_r    <= (rq_w < 0) ? MW'(-17'(rq_w)) : MW'(17'(rq_w));
            state_r <= S_IP;
          end else begin
            ma_r    <= MW'(dturn_r);
            mb_r    <= MW'($signed({1'b0, gain_r}));
            state_r <= S_PWR;
          end
        end
        S_IP: begin
          // signed square, inertia untouched
          res_left_r  <= 18'(prod_15);
          res_right_r <= -18'(prod_15);
          state_r     <= S_OUT;
        end
        S_PWR: begin
          inertia_r <= inr_new;
          ma_r      <= MW'(acmd);
          mb_r      <= MW'(26'(rq_r) + 26'(inr_new));
          state_r   <= S_ANG1;
        end
        S_ANG1: begin
          ma_r    <= MW'(prod_15);
          mb_r    <= MW'($signed({1'b0, sens_r}));
          state_r <= S_ANG2;
        end
        S_ANG2: begin
          res_left_r  <= cdm_pkg::sat_out(33'(cmd_r) + 33'(ang));
          res_right_r <= cdm_pkg::sat_out(33'(cmd_r) - 33'(ang));
          // decay by 1.0 toward zero
          if (inertia_r > cdm_pkg::ACC_ONE) begin
            inertia_r <= inertia_r - cdm_pkg::ACC_ONE;
          end else if (inertia_r < -cdm_pkg::ACC_ONE) begin
            inertia_r <= inertia_r + cdm_pkg::ACC_ONE;
          end else begin
            inertia_r <= '0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // park in the output register once it is free
          if (!out_valid_r || !out_stall) begin
            out_left_r  <= res_left_r;
            out_right_r <= res_right_r;
            out_tip_r   <= in_place_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_left_drive       = out_left_r;
  assign out_right_drive      = out_right_r;
  assign out_turning_in_place = out_tip_r;

endmodule
